/* sv/life_pkg.sv */
// ----------------------------------------------------------------------------
// life_pkg: shared types, constants and the Life rule
// Word types for the cell and result channels, CSR codes, reset values
// and the neighbor-count rule used by the stencil.
// ----------------------------------------------------------------------------
package life_pkg;

   localparam int MAX_ROW_CELLS_DEFAULT = 128;
   localparam int MAX_ROWS_DEFAULT      = 1024;

   localparam int ROW_LEN_REG_W = 8;
   localparam int ROW_CNT_REG_W = 11;
   localparam int OUT_ROW_W     = 10;
   localparam int OUT_COL_W     = 7;
   localparam int CSR_INDEX_W   = 2;
   localparam int CSR_DATA_W    = 11;
   localparam int WINDOW_COLS   = 3;
   localparam int WINDOW_W      = 9;

   // smallest padded extent: border, one interior cell, border
   localparam int MIN_PADDED_EXTENT = 3;
   // first padded row/column at which a full window is present
   localparam int FIRST_EMIT_POS    = 2;

   localparam logic [ROW_LEN_REG_W-1:0] ROW_LEN_RESET = 8'd102;
   localparam logic [ROW_CNT_REG_W-1:0] ROW_CNT_RESET = 11'd52;

   localparam logic MODE_MOORE       = 1'b0;
   localparam logic MODE_VON_NEUMANN = 1'b1;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_NEIGHBOUR_MODE = 2'd0,
      CSR_ROW_LENGTH     = 2'd1,
      CSR_ROW_COUNT      = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic cell_alive;
      logic frame_start;
   } req_word_type;

   typedef struct packed {
      logic                 next_alive;
      logic [OUT_ROW_W-1:0] out_row;
      logic [OUT_COL_W-1:0] out_col;
      logic                 last_of_frame;
   } rsp_word_type;

   // one window column: bit 0 top row, bit 2 bottom row
   typedef logic [2:0] win_col_type;

   // line store entry: the two rows above the incoming cell
   typedef struct packed {
      logic upper;
      logic middle;
   } line_entry_type;

   // window bit = column*3 + row, column 0 oldest, row 0 top
   function automatic logic next_state(input logic [WINDOW_W-1:0] win, input logic mode);
      logic [3:0] n;
      n = 4'(win[3]) + 4'(win[5]) + 4'(win[1]) + 4'(win[7]);
      if (mode == MODE_MOORE) begin
         n = n + 4'(win[0]) + 4'(win[2]) + 4'(win[6]) + 4'(win[8]);
      end
      if (n == 4'd3) begin
         return 1'b1;
      end else if (n == 4'd2) begin
         return win[4];
      end
      return 1'b0;
   endfunction

endpackage

/* sv/life_line_store.sv */
// ----------------------------------------------------------------------------
// life_line_store: two-row line buffer
// One entry per column holding the cells of the two previous rows.
// Registered read with a bypass for a write to the same column on the
// read edge.
// ----------------------------------------------------------------------------
module life_line_store #(
   parameter int DEPTH  = 128,
   parameter int ADDR_W = 7
) (
   input  logic                     clock,
   input  logic                     rd_en,
   input  logic [ADDR_W-1:0]        rd_addr,
   input  logic                     wr_en,
   input  logic [ADDR_W-1:0]        wr_addr,
   input  life_pkg::line_entry_type wr_data,
   output life_pkg::line_entry_type rd_data
);
   import life_pkg::*;

   line_entry_type mem [DEPTH];
   line_entry_type rd_q_ff;
   line_entry_type fwd_data_ff;
   logic           fwd_hit_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_q_ff <= mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         fwd_hit_ff  <= wr_en && (wr_addr == rd_addr);
         fwd_data_ff <= wr_data;
      end
   end

   assign rd_data = fwd_hit_ff ? fwd_data_ff : rd_q_ff;

endmodule

/* sv/life_window_cell.sv */
// ----------------------------------------------------------------------------
// life_window_cell: one column of the 3x3 window
// Holds three vertical cells and passes them to its left neighbor on
// every shift.
// ----------------------------------------------------------------------------
module life_window_cell (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  shift_en,
   input  life_pkg::win_col_type col_in,
   output life_pkg::win_col_type col_q
);
   import life_pkg::*;

   win_col_type col_ff;
   win_col_type col_in_w;

   assign col_in_w = shift_en ? col_in : col_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
      end else begin
         col_ff <= col_in_w;
      end
   end

   assign col_q = col_ff;

endmodule

/* sv/life_automaton_stencil.sv */
// Path: an accepted cell word is registered in stage 1, then its result word (if any) in the output register.
// Throughput: one cell word per clock unless stage 1 holds a result word behind a full output;
//   the window shift and line-store read-modify-write overlap across words.
// Stalls: with a result waiting, words enter until one that yields a result fills stage 1.
// Reset: positions and window clear to zero, CSRs take mode 0, length 102, count 52;
//   the line store is not cleared and needs no clearing pass.
// ----------------------------------------------------------------------------
// life_automaton_stencil: streaming Life generation, 3x3 stencil
// Raster cells in, next state of each interior cell out, with its padded
// row/column and an end-of-frame flag.
// ----------------------------------------------------------------------------
module life_automaton_stencil #(
   parameter int MAX_ROW_CELLS = life_pkg::MAX_ROW_CELLS_DEFAULT,
   parameter int MAX_ROWS      = life_pkg::MAX_ROWS_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   // cell word channel
   input  logic                               req_valid,
   output logic                               req_ready,
   input  life_pkg::req_word_type             req_word,
   // result word channel
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output life_pkg::rsp_word_type             rsp_word,
   // CSR write channel
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [life_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [life_pkg::CSR_DATA_W-1:0]    csr_data
);
   import life_pkg::*;

   localparam int COL_W = $clog2(MAX_ROW_CELLS);
   localparam int ROW_W = $clog2(MAX_ROWS);
   // compare widths: wide enough for the register and for the max extent
   localparam int LEN_W = (COL_W + 1 > ROW_LEN_REG_W) ? COL_W + 1 : ROW_LEN_REG_W;
   localparam int CNT_W = (ROW_W + 1 > ROW_CNT_REG_W) ? ROW_W + 1 : ROW_CNT_REG_W;

   // ---------------- CSRs ----------------
   logic                     mode_ff;
   logic [ROW_LEN_REG_W-1:0] row_len_ff;
   logic [ROW_CNT_REG_W-1:0] row_cnt_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff    <= MODE_MOORE;
         row_len_ff <= ROW_LEN_RESET;
         row_cnt_ff <= ROW_CNT_RESET;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_NEIGHBOUR_MODE: begin
               mode_ff <= csr_data[0];
            end
            CSR_ROW_LENGTH: begin
               row_len_ff <= csr_data[ROW_LEN_REG_W-1:0];
            end
            CSR_ROW_COUNT: begin
               row_cnt_ff <= csr_data[ROW_CNT_REG_W-1:0];
            end
            default: begin
               // unmapped index: write dropped
            end
         endcase
      end
   end

   // clamp the extents between the smallest padded extent and what the stores and counters can hold
   logic [LEN_W-1:0] len_reg;
   logic [LEN_W-1:0] len_eff;
   logic [CNT_W-1:0] cnt_reg;
   logic [CNT_W-1:0] cnt_eff;

   assign len_reg = LEN_W'(row_len_ff);
   assign cnt_reg = CNT_W'(row_cnt_ff);

   always_comb begin
      priority if (len_reg < LEN_W'(MIN_PADDED_EXTENT)) begin
         len_eff = LEN_W'(MIN_PADDED_EXTENT);
      end else if (len_reg > LEN_W'(MAX_ROW_CELLS)) begin
         len_eff = LEN_W'(MAX_ROW_CELLS);
      end else begin
         len_eff = len_reg;
      end
      priority if (cnt_reg < CNT_W'(MIN_PADDED_EXTENT)) begin
         cnt_eff = CNT_W'(MIN_PADDED_EXTENT);
      end else if (cnt_reg > CNT_W'(MAX_ROWS)) begin
         cnt_eff = CNT_W'(MAX_ROWS);
      end else begin
         cnt_eff = cnt_reg;
      end
   end

   // ---------------- handshake / stage control ----------------
   // Stage 1 holds one word while its line-store data is read; it drains
   // into the window and, if it produces a result, into the output register.
   logic s1_valid_ff;
   logic s1_emit_ff;
   logic s1_advance;
   logic req_fire;
   logic rsp_valid_ff;

   assign s1_advance = s1_valid_ff && (!s1_emit_ff || !rsp_valid_ff || rsp_ready);
   assign req_ready  = !s1_valid_ff || s1_advance;
   assign req_fire   = req_valid && req_ready;

   // ---------------- stage 0: position tracking ----------------
   logic [COL_W-1:0] col_pos_ff;
   logic [COL_W-1:0] col_pos_in;
   logic [ROW_W-1:0] row_pos_ff;
   logic [ROW_W-1:0] row_pos_in;
   logic [COL_W-1:0] c_cur;
   logic [ROW_W-1:0] r_cur;
   logic [LEN_W-1:0] c_ext;
   logic [LEN_W-1:0] c_inc;
   logic [CNT_W-1:0] r_ext;
   logic [CNT_W-1:0] r_inc;
   logic             emit_w;
   logic             last_w;
   logic [COL_W-1:0] c_m1;
   logic [ROW_W-1:0] r_m1;

   // frame_start forces this word to position (0,0)
   assign c_cur = req_word.frame_start ? '0 : col_pos_ff;
   assign r_cur = req_word.frame_start ? '0 : row_pos_ff;
   assign c_ext = LEN_W'(c_cur);
   assign r_ext = CNT_W'(r_cur);
   assign c_inc = c_ext + LEN_W'(1);
   assign r_inc = r_ext + CNT_W'(1);
   assign c_m1  = c_cur - COL_W'(1);
   assign r_m1  = r_cur - ROW_W'(1);

   // a position past a shrunk extent just wraps without a result
   assign emit_w = (r_ext >= CNT_W'(FIRST_EMIT_POS)) && (r_ext < cnt_eff) &&
                   (c_ext >= LEN_W'(FIRST_EMIT_POS)) && (c_ext < len_eff);
   assign last_w = (r_ext == cnt_eff - CNT_W'(1)) && (c_ext == len_eff - LEN_W'(1));

   always_comb begin
      if (c_inc >= len_eff) begin
         col_pos_in = '0;
         row_pos_in = (r_inc >= cnt_eff) ? '0 : ROW_W'(r_inc);
      end else begin
         col_pos_in = COL_W'(c_inc);
         row_pos_in = r_cur;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_pos_ff <= '0;
         row_pos_ff <= '0;
      end else if (req_fire) begin
         col_pos_ff <= col_pos_in;
         row_pos_ff <= row_pos_in;
      end
   end

   // ---------------- stage 1 registers ----------------
   logic                 s1_cell_ff;
   logic [COL_W-1:0]     s1_addr_ff;
   logic [OUT_ROW_W-1:0] s1_row_ff;
   logic [OUT_COL_W-1:0] s1_col_ff;
   logic                 s1_last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s1_emit_ff  <= 1'b0;
      end else if (req_fire) begin
         s1_valid_ff <= 1'b1;
         s1_emit_ff  <= emit_w;
      end else if (s1_advance) begin
         s1_valid_ff <= 1'b0;
         s1_emit_ff  <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_cell_ff <= req_word.cell_alive;
         s1_addr_ff <= c_cur;
         s1_row_ff  <= OUT_ROW_W'(r_m1);
         s1_col_ff  <= OUT_COL_W'(c_m1);
         s1_last_ff <= last_w;
      end
   end

   // ---------------- line store ----------------
   // read at accept, write back {middle -> upper, new cell -> middle}
   // when the word leaves stage 1
   line_entry_type ls_rd;
   line_entry_type ls_wr;

   assign ls_wr.upper  = ls_rd.middle;
   assign ls_wr.middle = s1_cell_ff;

   life_line_store #(
      .DEPTH  (MAX_ROW_CELLS),
      .ADDR_W (COL_W)
   ) u_line_store (
      .clock   (clock),
      .rd_en   (req_fire),
      .rd_addr (c_cur),
      .wr_en   (s1_advance),
      .wr_addr (s1_addr_ff),
      .wr_data (ls_wr),
      .rd_data (ls_rd)
   );

   // ---------------- window: chain of column cells ----------------
   // cell 2 takes the new column, each cell hands its column leftward
   win_col_type col_new;
   win_col_type win_col [WINDOW_COLS];
   win_col_type win_feed [WINDOW_COLS];
   logic [WINDOW_W-1:0] window_next;

   assign col_new = {s1_cell_ff, ls_rd.middle, ls_rd.upper};

   genvar gi;
   generate
      for (gi = 0; gi < WINDOW_COLS; gi++) begin : g_win
         if (gi == WINDOW_COLS - 1) begin : g_head
            assign win_feed[gi] = col_new;
         end else begin : g_link
            assign win_feed[gi] = win_col[gi+1];
         end
         life_window_cell u_cell (
            .clock    (clock),
            .reset    (reset),
            .shift_en (s1_advance),
            .col_in   (win_feed[gi]),
            .col_q    (win_col[gi])
         );
      end
   endgenerate

   // window as it stands after this word's shift
   assign window_next = {col_new, win_col[2], win_col[1]};

   // ---------------- output register ----------------
   rsp_word_type rsp_word_ff;
   rsp_word_type rsp_word_in;

   always_comb begin
      rsp_word_in.next_alive    = next_state(window_next, mode_ff);
      rsp_word_in.out_row       = s1_row_ff;
      rsp_word_in.out_col       = s1_col_ff;
      rsp_word_in.last_of_frame = s1_last_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (s1_advance && s1_emit_ff) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_advance && s1_emit_ff) begin
         rsp_word_ff <= rsp_word_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

   // ---------------- assertions ----------------
   // a new result only appears after a result-bearing word left stage 1
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(s1_advance && s1_emit_ff))
      else $error("result appeared without a stage-1 word");

   // frame_start restarts at column 0, so the next word is at column 1
   a_frame_restart: assert property (@(posedge clock) disable iff (reset)
      req_fire && req_word.frame_start |=> col_pos_ff == COL_W'(1))
      else $error("frame_start did not restart the column count");

   // a stalled stage-1 word is neither lost nor replaced
   a_s1_hold: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && !s1_advance |=> s1_valid_ff && $stable(s1_addr_ff))
      else $error("stalled stage-1 word dropped");

   // results never name a border cell
   a_interior: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && s1_emit_ff |-> (s1_row_ff != '0) && (s1_col_ff != '0))
      else $error("result on border position");

endmodule
